// ===== design/lbp_pkg.sv =====
// Shared constants and types for the 3x3 local binary pattern stream block.
// No dependencies; imported by every module of the block except the RAM.
package lbp_pkg;

   localparam int PIXEL_W      = 8;
   localparam int MAX_WIDTH    = 1024;
   localparam int COL_W        = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
   localparam int CFG_WIDTH_W  = 11;
   localparam int CFG_HEIGHT_W = 12;
   localparam int WCMP_W       = (CFG_WIDTH_W > COL_W + 1) ? CFG_WIDTH_W : COL_W + 1;

   localparam int LINE_W       = 2 * PIXEL_W;
   localparam int COLUMN_W     = 3 * PIXEL_W;

   localparam int CSR_INDEX_W  = 1;
   localparam int CSR_DATA_W   = 12;

   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_WIDTH  = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_HEIGHT = 1'd1;

   localparam logic [CFG_WIDTH_W-1:0]  WIDTH_RESET  = 11'd160;
   localparam logic [CFG_HEIGHT_W-1:0] HEIGHT_RESET = 12'd120;

   typedef struct packed {
      logic [COL_W-1:0] col;
      logic             emit;
      logic             row_end;
      logic             frame_end;
   } scan_info_type;

endpackage

// ===== design/lbp_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module lbp_ram #(
   parameter int DATA_W = 8,
   parameter int DEPTH  = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [DATA_W-1:0]        wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [DATA_W-1:0]        rd_data
);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      // read returns the old contents on a same-address write
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/lbp_scan.sv =====
// Raster position tracking and frame geometry registers.
// Depends on lbp_pkg.
module lbp_scan (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_write_en,
   input  logic [lbp_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [lbp_pkg::CSR_DATA_W-1:0]     csr_write_data,
   input  logic                               accept,
   input  logic                               frame_start,
   output logic                               enter,
   output lbp_pkg::scan_info_type             info
);
   import lbp_pkg::*;

   logic [CFG_WIDTH_W-1:0]  frame_width_ff;
   logic [CFG_HEIGHT_W-1:0] frame_height_ff;
   logic [COL_W-1:0]        col_ff, col_in;
   logic [CFG_HEIGHT_W-1:0] row_ff, row_in;
   logic                    active_ff, active_in;

   logic [COL_W-1:0]        col_cur;
   logic [CFG_HEIGHT_W-1:0] row_cur;
   logic                    active_cur;
   logic [COL_W-1:0]        last_col_idx;
   logic [CFG_HEIGHT_W-1:0] last_row_idx;
   logic                    last_col;
   logic                    last_row;

   always_comb begin
      // last column index of the clamped width
      if (WCMP_W'(frame_width_ff) > WCMP_W'(MAX_WIDTH)) begin
         last_col_idx = COL_W'(MAX_WIDTH - 1);
      end else if (frame_width_ff < CFG_WIDTH_W'(3)) begin
         last_col_idx = COL_W'(2);
      end else begin
         last_col_idx = COL_W'(frame_width_ff - CFG_WIDTH_W'(1));
      end

      if (frame_height_ff < CFG_HEIGHT_W'(3)) begin
         last_row_idx = CFG_HEIGHT_W'(2);
      end else begin
         last_row_idx = frame_height_ff - CFG_HEIGHT_W'(1);
      end

      col_cur    = frame_start ? '0 : col_ff;
      row_cur    = frame_start ? '0 : row_ff;
      active_cur = frame_start | active_ff;

      last_col = col_cur >= last_col_idx;
      last_row = row_cur >= last_row_idx;

      info.col       = col_cur;
      info.emit      = (row_cur >= CFG_HEIGHT_W'(2)) && (col_cur >= COL_W'(2));
      info.row_end   = last_col;
      info.frame_end = last_col & last_row;

      enter = accept & active_cur;

      col_in    = col_ff;
      row_in    = row_ff;
      active_in = active_ff;
      if (enter) begin
         active_in = 1'b1;
         if (last_col) begin
            col_in = '0;
            if (last_row) begin
               active_in = 1'b0;
               row_in    = '0;
            end else begin
               row_in = row_cur + CFG_HEIGHT_W'(1);
            end
         end else begin
            col_in = col_cur + COL_W'(1);
            row_in = row_cur;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= WIDTH_RESET;
         frame_height_ff <= HEIGHT_RESET;
         col_ff          <= '0;
         row_ff          <= '0;
         active_ff       <= 1'b0;
      end else begin
         col_ff    <= col_in;
         row_ff    <= row_in;
         active_ff <= active_in;
         if (csr_write_en) begin
            case (csr_index)
               CSR_FRAME_WIDTH:  frame_width_ff  <= csr_write_data[CFG_WIDTH_W-1:0];
               CSR_FRAME_HEIGHT: frame_height_ff <= csr_write_data[CFG_HEIGHT_W-1:0];
               default: ;
            endcase
         end
      end
   end

endmodule

// ===== design/lbp_code.sv =====
// 3x3 window of the two previous columns and the neighbour comparators.
// Depends on lbp_pkg.
module lbp_code (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          shift,
   input  logic [lbp_pkg::COLUMN_W-1:0]  column,
   output logic [lbp_pkg::PIXEL_W-1:0]   code
);
   import lbp_pkg::*;

   // each column is {top, middle, bottom}
   logic [COLUMN_W-1:0] prev1_ff;
   logic [COLUMN_W-1:0] prev2_ff;

   logic [PIXEL_W-1:0] centre;

   always_comb begin
      centre  = prev1_ff[PIXEL_W +: PIXEL_W];
      code[7] = prev2_ff[2*PIXEL_W +: PIXEL_W] > centre;
      code[6] = prev1_ff[2*PIXEL_W +: PIXEL_W] > centre;
      code[5] = column[2*PIXEL_W +: PIXEL_W]   > centre;
      code[4] = column[PIXEL_W +: PIXEL_W]     > centre;
      code[3] = column[0 +: PIXEL_W]           > centre;
      code[2] = prev1_ff[0 +: PIXEL_W]         > centre;
      code[1] = prev2_ff[0 +: PIXEL_W]         > centre;
      code[0] = prev2_ff[PIXEL_W +: PIXEL_W]   > centre;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev1_ff <= '0;
         prev2_ff <= '0;
      end else if (shift) begin
         prev2_ff <= prev1_ff;
         prev1_ff <= column;
      end
   end

endmodule

// ===== design/lbp_3x3_pixel_stream_top.sv =====
// Top level of the 3x3 local binary pattern pixel stream block.
// Depends on lbp_pkg, lbp_ram, lbp_scan and lbp_code.
//
//   port group   dir   handshake           payload
//   req_         in    req_valid/ready     pixel, frame_start
//   rsp_         out   rsp_valid/ready     lbp_code, row_end, frame_end
//   csr_         in    csr_write_en        csr_index, csr_write_data
//
// One pixel word per clock unless results stall; compare stage, then result register.
// Line store read (registered) sets the depth: address stage, then compare stage.
// Synchronous reset clears position, window and valids; line store is not cleared.
// A stalled result holds the compare stage; req_ready drops only while both are full.
module lbp_3x3_pixel_stream_top (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [lbp_pkg::PIXEL_W-1:0]        req_pixel,
   input  logic                               req_frame_start,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [lbp_pkg::PIXEL_W-1:0]        rsp_lbp_code,
   output logic                               rsp_row_end,
   output logic                               rsp_frame_end,
   input  logic                               csr_write_en,
   input  logic [lbp_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [lbp_pkg::CSR_DATA_W-1:0]     csr_write_data
);
   import lbp_pkg::*;

   logic          req_accept;
   logic          enter;
   scan_info_type scan_info;

   // compare stage
   logic                b_valid_ff;
   logic [PIXEL_W-1:0]  b_pixel_ff;
   scan_info_type       b_info_ff;
   logic                b_adv;
   logic                byp_ff, byp_in;
   logic [LINE_W-1:0]   byp_data_ff;
   logic [LINE_W-1:0]   ram_rd_data;
   logic [LINE_W-1:0]   line;
   logic [LINE_W-1:0]   wr_data;
   logic [COLUMN_W-1:0] column;
   logic [PIXEL_W-1:0]  code;

   // result register
   logic               out_valid_ff;
   logic [PIXEL_W-1:0] out_code_ff;
   logic               out_row_end_ff;
   logic               out_frame_end_ff;

   assign b_adv      = b_valid_ff & (~out_valid_ff | rsp_ready);
   assign req_ready  = ~b_valid_ff | b_adv;
   assign req_accept = req_valid & req_ready;

   lbp_scan u_scan (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data),
      .accept         (req_accept),
      .frame_start    (req_frame_start),
      .enter          (enter),
      .info           (scan_info)
   );

   // both line stores in one word: older row high byte, newer row low byte
   lbp_ram #(
      .DATA_W (LINE_W),
      .DEPTH  (MAX_WIDTH)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (b_adv),
      .wr_addr (b_info_ff.col),
      .wr_data (wr_data),
      .rd_en   (enter),
      .rd_addr (scan_info.col),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      line    = byp_ff ? byp_data_ff : ram_rd_data;
      wr_data = {line[PIXEL_W-1:0], b_pixel_ff};
      column  = {line, b_pixel_ff};
      // same column written while it is read (back-to-back frame starts)
      byp_in  = b_adv & (b_info_ff.col == scan_info.col);
   end

   lbp_code u_code (
      .clock  (clock),
      .reset  (reset),
      .shift  (b_adv),
      .column (column),
      .code   (code)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_accept) begin
            b_valid_ff <= enter;
         end else if (b_adv) begin
            b_valid_ff <= 1'b0;
         end

         if (b_adv) begin
            out_valid_ff <= b_info_ff.emit | (out_valid_ff & ~rsp_ready);
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (enter) begin
         b_pixel_ff  <= req_pixel;
         b_info_ff   <= scan_info;
         byp_ff      <= byp_in;
         byp_data_ff <= wr_data;
      end
      if (b_adv && b_info_ff.emit) begin
         out_code_ff      <= code;
         out_row_end_ff   <= b_info_ff.row_end;
         out_frame_end_ff <= b_info_ff.frame_end;
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_lbp_code  = out_code_ff;
   assign rsp_row_end   = out_row_end_ff;
   assign rsp_frame_end = out_frame_end_ff;

endmodule

// ===== dv/testbench.sv =====
// Self-checking bench for the 3x3 local binary pattern pixel stream block.
// Needs lbp_pkg and lbp_3x3_pixel_stream_top; drives pixel words with random
// idling and checks every code word against its own line-store predictor.
module testbench;
   import lbp_pkg::*;

   localparam int ITEM_TARGET   = 1500;
   localparam int TAIL_ITEMS    = 200;
   localparam int HOLD_AT       = 300;
   localparam int PAUSE_AT      = 700;
   localparam int HOLD_CYCLES   = 300;
   localparam int SETTLE_CYCLES = 6;
   localparam int DRAIN_CYCLES  = 20;
   localparam int MAX_PRINTS    = 200;
   localparam int CYCLE_LIMIT   = 1000000;

   typedef struct packed {
      logic [PIXEL_W-1:0] code;
      logic               row_end;
      logic               frame_end;
   } code_word_type;

   typedef enum logic [1:0] {DIR_PREDICT, DIR_NO_CODE, DIR_CODE, DIR_CSR} dir_kind_type;

   typedef struct packed {
      dir_kind_type            kind;
      logic [CSR_INDEX_W-1:0]  index;
      logic [CSR_DATA_W-1:0]   data;
      logic [PIXEL_W-1:0]      pixel;
      logic                    start;
      logic [PIXEL_W-1:0]      code;
      logic                    row_end;
      logic                    frame_end;
   } directed_row_type;

   localparam int DIR_ROWS = 26;
   localparam directed_row_type DIRECTED [DIR_ROWS] = '{
      // stray pixels straight after reset: no frame yet
      '{DIR_NO_CODE, '0, '0, 8'hFF, 1'b0, '0, 1'b0, 1'b0},
      '{DIR_NO_CODE, '0, '0, 8'h00, 1'b0, '0, 1'b0, 1'b0},
      '{DIR_NO_CODE, '0, '0, 8'hA5, 1'b0, '0, 1'b0, 1'b0},
      // below range, both clamp to 3
      '{DIR_CSR, CSR_FRAME_WIDTH,  12'd2, '0, 1'b0, '0, 1'b0, 1'b0},
      '{DIR_CSR, CSR_FRAME_HEIGHT, 12'd0, '0, 1'b0, '0, 1'b0, 1'b0},
      // dark centre, all neighbours white
      '{DIR_PREDICT, '0, '0, 8'hFF, 1'b1, '0, 1'b0, 1'b0},
      '{DIR_PREDICT, '0, '0, 8'hFF, 1'b0, '0, 1'b0, 1'b0},
      '{DIR_PREDICT, '0, '0, 8'hFF, 1'b0, '0, 1'b0, 1'b0},
      '{DIR_PREDICT, '0, '0, 8'hFF, 1'b0, '0, 1'b0, 1'b0},
      '{DIR_PREDICT, '0, '0, 8'h00, 1'b0, '0, 1'b0, 1'b0},
      '{DIR_PREDICT, '0, '0, 8'hFF, 1'b0, '0, 1'b0, 1'b0},
      '{DIR_PREDICT, '0, '0, 8'hFF, 1'b0, '0, 1'b0, 1'b0},
      '{DIR_PREDICT, '0, '0, 8'hFF, 1'b0, '0, 1'b0, 1'b0},
      '{DIR_CODE,    '0, '0, 8'hFF, 1'b0, 8'hFF, 1'b1, 1'b1},
      // frame over, so this one is dropped
      '{DIR_NO_CODE, '0, '0, 8'h5A, 1'b0, '0, 1'b0, 1'b0},
      // short frame, cut off by the next start
      '{DIR_PREDICT, '0, '0, 8'h11, 1'b1, '0, 1'b0, 1'b0},
      '{DIR_PREDICT, '0, '0, 8'h22, 1'b0, '0, 1'b0, 1'b0},
      // centre 7F: equal neighbours must stay clear
      '{DIR_PREDICT, '0, '0, 8'h80, 1'b1, '0, 1'b0, 1'b0},
      '{DIR_PREDICT, '0, '0, 8'h7F, 1'b0, '0, 1'b0, 1'b0},
      '{DIR_PREDICT, '0, '0, 8'h00, 1'b0, '0, 1'b0, 1'b0},
      '{DIR_PREDICT, '0, '0, 8'h80, 1'b0, '0, 1'b0, 1'b0},
      '{DIR_PREDICT, '0, '0, 8'h7F, 1'b0, '0, 1'b0, 1'b0},
      '{DIR_PREDICT, '0, '0, 8'hFF, 1'b0, '0, 1'b0, 1'b0},
      '{DIR_PREDICT, '0, '0, 8'h7F, 1'b0, '0, 1'b0, 1'b0},
      '{DIR_PREDICT, '0, '0, 8'h80, 1'b0, '0, 1'b0, 1'b0},
      '{DIR_CODE,    '0, '0, 8'h7E, 1'b0, 8'h95, 1'b1, 1'b1}
   };

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic [PIXEL_W-1:0]     req_pixel = '0;
   logic                   req_frame_start = 1'b0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic [PIXEL_W-1:0]     rsp_lbp_code;
   logic                   rsp_row_end;
   logic                   rsp_frame_end;
   logic                   csr_write_en = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_write_data = '0;

   lbp_3x3_pixel_stream_top DUT (.*);

   // predictor state
   logic [CFG_WIDTH_W-1:0]  width_reg  = WIDTH_RESET;
   logic [CFG_HEIGHT_W-1:0] height_reg = HEIGHT_RESET;
   logic [PIXEL_W-1:0]      rows_back2 [MAX_WIDTH] = '{default: 8'h00};
   logic [PIXEL_W-1:0]      rows_back1 [MAX_WIDTH] = '{default: 8'h00};
   logic [2*COLUMN_W-1:0]   win_cols = '0;
   int unsigned             col_idx = 0;
   int unsigned             row_idx = 0;
   bit                      frame_live = 1'b0;

   code_word_type expected_codes [$];
   int         mismatches = 0;
   int         random_items = 0;
   int         cycle_count = 0;
   bit         count_items = 1'b0;
   bit         quiet_tail = 1'b0;
   bit         sender_idles = 1'b0;
   bit         hold_pending = 1'b0;
   bit         hold_done = 1'b0;
   bit         pause_done = 1'b0;
   int         pixel_style = 0;

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   function automatic int unsigned frame_cols();
      int unsigned w;
      w = width_reg;
      if (w < 3) w = 3;
      if (w > MAX_WIDTH) w = MAX_WIDTH;
      return w;
   endfunction

   function automatic int unsigned frame_rows();
      int unsigned h;
      h = height_reg;
      if (h < 3) h = 3;
      return h;
   endfunction

   // One pixel word in; returns 1 when it completes a window.
   function automatic bit predict_code(input logic [PIXEL_W-1:0] px, input logic fs,
                                       output code_word_type res);
      int unsigned      w, h, c;
      logic [7:0]       top, mid, centre;
      logic [23:0]      col, p1, p2;
      bit               last, emitted;
      w = frame_cols();
      h = frame_rows();
      res = '0;
      emitted = 1'b0;
      if (fs) begin
         frame_live = 1'b1;
         col_idx = 0;
         row_idx = 0;
      end
      if (!frame_live) return 1'b0;
      c = (col_idx >= MAX_WIDTH) ? MAX_WIDTH - 1 : col_idx;
      top = rows_back2[c];
      mid = rows_back1[c];
      rows_back2[c] = mid;
      rows_back1[c] = px;
      col = {top, mid, px};
      last = c >= w - 1;
      if (row_idx >= 2 && c >= 2) begin
         // p1 is the centre column, p2 the one left of it
         p1 = win_cols[23:0];
         p2 = win_cols[47:24];
         centre = p1[15:8];
         res.code = {p2[23:16] > centre, p1[23:16] > centre, top > centre, mid > centre,
                     px > centre, p1[7:0] > centre, p2[7:0] > centre, p2[15:8] > centre};
         res.row_end = last;
         res.frame_end = last && row_idx >= h - 1;
         emitted = 1'b1;
      end
      win_cols = {win_cols[23:0], col};
      if (last) begin
         col_idx = 0;
         if (row_idx >= h - 1) begin
            frame_live = 1'b0;
            row_idx = 0;
         end else begin
            row_idx = (row_idx + 1) & 32'hFFF;
         end
      end else begin
         col_idx = c + 1;
      end
      return emitted;
   endfunction

   function automatic logic [PIXEL_W-1:0] pick_pixel(input int style);
      case (style)
         0: return 8'($urandom_range(0, 255));
         1: return 8'($urandom_range(120, 123));  // lots of ties with the centre
         default: begin
            case ($urandom_range(0, 2))
               0: return 8'h00;
               1: return 8'hFF;
               default: return 8'($urandom_range(0, 255));
            endcase
         end
      endcase
   endfunction

   task automatic report_mismatch(input string msg);
      if (mismatches < MAX_PRINTS) $display("MISMATCH @%0d: %s", cycle_count, msg);
      mismatches++;
   endtask

   task automatic offer_pixel(input logic [PIXEL_W-1:0] px, input logic fs);
      req_valid <= 1'b1;
      req_pixel <= px;
      req_frame_start <= fs;
      do @(posedge clock); while (!req_ready);
   endtask

   // Registers change only once the block has drained.
   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      req_valid <= 1'b0;
      do @(posedge clock); while (expected_codes.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_write_data <= data;
      @(posedge clock);
      csr_write_en <= 1'b0;
      if (idx == CSR_FRAME_WIDTH) width_reg = data[CFG_WIDTH_W-1:0];
      else height_reg = data[CFG_HEIGHT_W-1:0];
   endtask

   task automatic feed_pixel(input logic [PIXEL_W-1:0] px, input logic fs);
      code_word_type res;
      if (count_items && !pause_done && random_items >= PAUSE_AT) begin
         pause_done = 1'b1;
         req_valid <= 1'b0;
         do @(posedge clock); while (expected_codes.size() != 0);
      end else if (sender_idles && !quiet_tail && $urandom_range(0, 7) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
      if (count_items && !hold_done && random_items >= HOLD_AT) begin
         hold_done = 1'b1;
         hold_pending = 1'b1;
      end
      if (count_items && (fs || frame_live)) random_items++;
      quiet_tail = count_items && random_items >= ITEM_TARGET - TAIL_ITEMS;
      offer_pixel(px, fs);
      if (predict_code(px, fs, res)) expected_codes.push_back(res);
   endtask

   // Frames at one register setting. Shapes: stray words, cut-off frame, whole frame (<= 4096).
   task automatic run_frames(input logic [CSR_DATA_W-1:0] wd, input logic [CSR_DATA_W-1:0] hd,
                             input int quota, input bit full_only);
      int unsigned w, h, total, len, sent;
      int          shape;
      bit          opening;
      write_reg(CSR_FRAME_WIDTH, wd);
      write_reg(CSR_FRAME_HEIGHT, hd);
      w = frame_cols();
      h = frame_rows();
      total = w * h;
      sent = 0;
      opening = 1'b1;
      while (sent < quota) begin
         // first shape always opens a frame, so an old frame never runs on at a new width
         shape = full_only ? 2 : (opening ? $urandom_range(1, 9) : $urandom_range(0, 9));
         opening = 1'b0;
         pixel_style = $urandom_range(0, 2);
         sender_idles = $urandom_range(0, 3) != 0;
         if (shape == 0) len = $urandom_range(1, 4);
         else if (shape == 1) len = $urandom_range(1, total - 1);
         else len = (total > 4096) ? 2 * w + $urandom_range(3, 600) : total;
         for (int unsigned i = 0; i < len; i++)
            feed_pixel(pick_pixel(pixel_style), shape != 0 && i == 0);
         sent += len;
      end
   endtask

   // result side: random stalls while cycle_count bit 9 is set, plus one long hold
   initial begin
      forever begin
         @(posedge clock);
         if (hold_pending) begin
            hold_pending = 1'b0;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else if (!quiet_tail && cycle_count[9] && $urandom_range(0, 15) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin : check_codes
      code_word_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_codes.size() == 0) begin
            report_mismatch($sformatf("unexpected code word %02h row_end %b frame_end %b",
                                      rsp_lbp_code, rsp_row_end, rsp_frame_end));
         end else begin
            want = expected_codes.pop_front();
            if (rsp_lbp_code !== want.code || rsp_row_end !== want.row_end ||
                rsp_frame_end !== want.frame_end)
               report_mismatch($sformatf("code %02h/%b/%b, expected %02h/%b/%b",
                                         rsp_lbp_code, rsp_row_end, rsp_frame_end,
                                         want.code, want.row_end, want.frame_end));
         end
      end
   end

   initial begin
      directed_row_type       row;
      code_word_type          res;
      logic [CSR_DATA_W-1:0]  wd, hd;
      bit                     got, specials_done;
      specials_done = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < DIR_ROWS; i++) begin
         row = DIRECTED[i];
         if (row.kind == DIR_CSR) begin
            write_reg(row.index, row.data);
         end else begin
            offer_pixel(row.pixel, row.start);
            got = predict_code(row.pixel, row.start, res);
            if (row.kind == DIR_PREDICT && got) expected_codes.push_back(res);
            else if (row.kind == DIR_CODE)
               expected_codes.push_back(code_word_type'{row.code, row.row_end,
                                                        row.frame_end});
         end
      end

      count_items = 1'b1;
      while (random_items < ITEM_TARGET) begin
         case ($urandom_range(0, 9))
            0: wd = {1'($urandom_range(0, 1)), 11'($urandom_range(0, 2))};
            1: wd = {1'($urandom_range(0, 1)), 11'($urandom_range(17, 64))};
            default: wd = {1'($urandom_range(0, 1)), 11'($urandom_range(3, 16))};
         endcase
         case ($urandom_range(0, 9))
            0: hd = 12'($urandom_range(0, 2));
            1: hd = 12'($urandom_range(9, 20));
            default: hd = 12'($urandom_range(3, 8));
         endcase
         run_frames(wd, hd, $urandom_range(60, 200), 1'b0);
         if (!specials_done) begin
            // extreme sizes: tallest frame cut short, registers below range
            specials_done = 1'b1;
            run_frames(12'd3, 12'd4095, 1, 1'b1);
            run_frames(12'd1, 12'd1, 40, 1'b0);
         end
      end

      req_valid <= 1'b0;
      do @(posedge clock); while (expected_codes.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
